>>> rtl/rbci_pkg.sv
package rbci_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ProdW = 64;
  localparam int unsigned MulCycles = 32;

  typedef enum logic [1:0] {
    CMD_CONTACT = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_LOAD_P  = 2'd2,
    CMD_LOAD_O  = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_GX = 2'd0;
  localparam logic [1:0] REG_GY = 2'd1;
  localparam logic [1:0] REG_GZ = 2'd2;
  localparam logic [1:0] REG_MASS = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] depth;
    logic [30:0]        delta;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] ori_x;
    logic signed [31:0] ori_y;
    logic signed [31:0] ori_z;
    logic signed [31:0] spin_x;
    logic signed [31:0] spin_y;
    logic signed [31:0] spin_z;
  } out_req_t;

  // Control between sequencer and serial multiplier
  typedef struct packed {
    logic start;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

  // Saturate a 34-bit signed value to 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
    if (x > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -34'sh0_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

>>> rtl/rbci_mul.sv
// Bit-serial signed multiplier: one bit of b per cycle, then round and saturate.
module rbci_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  rbci_pkg::mul_ctl_t  ctl,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  output rbci_pkg::mul_sts_t  sts,
  output logic signed [31:0]  y
);
  import rbci_pkg::*;

  logic signed [ProdW-1:0] acc;
  logic signed [ProdW-1:0] mcand;
  logic [31:0]             mplier;
  logic [5:0]              cnt;
  logic                    busy;
  logic                    done;
  logic signed [ProdW-1:0] rnd;
  logic signed [ProdW-1:0] shf;
  localparam logic signed [ProdW-1:0] Half = ProdW'(1) <<< (FRAC_BITS - 1);

  // Final rounding and saturation of the full product
  always_comb begin
    rnd = acc + Half;
    shf = rnd >>> FRAC_BITS;
  end

  // Shift-add over all bits of b; top bit of b carries negative weight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy   <= 1'b1;
        cnt    <= '0;
        acc    <= '0;
        mcand  <= ProdW'(a);
        mplier <= b;
      end else if (busy) begin
        if (mplier[0]) begin
          if (cnt == 6'(MulCycles - 1)) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 6'd1;
        if (cnt == 6'(MulCycles - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (shf > 64'sh7FFF_FFFF) y = 32'sh7FFF_FFFF;
    else if (shf < -64'sh8000_0000) y = 32'sh8000_0000;
    else y = shf[31:0];
  end

  assign sts.busy = busy;
  assign sts.done = done;
endmodule

>>> rtl/rigid_body_contact_integrator.sv
// Channel | handshake              | payload
// in      | in_valid / in_ready    | in_data  (rbci_pkg::in_req_t)
// out     | out_valid / out_ready  | out_data (rbci_pkg::out_req_t)
// cfg     | cfg_we                 | cfg_index, cfg_data
// One request at a time. Loads issue no multiplies; a tick takes 9 serial multiplies,
// a contact 23, each in the shared bit-serial multiplier. Synchronous reset
// zeroes the body state and loads register defaults. A new request is taken once
// the prior result has left the output register; out_ready low holds the result
// and the block.
module rigid_body_contact_integrator #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rbci_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rbci_pkg::out_req_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import rbci_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ISS  = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  localparam logic signed [31:0] Percent = 32'(((64'd1 << FRAC_BITS) + 2) / 5);
  localparam logic signed [31:0] Slop = 32'(((64'd1 << FRAC_BITS) + 50) / 100);
  localparam logic signed [31:0] Bounce = 32'(((64'd9 << FRAC_BITS) + 2) / 5);
  localparam logic signed [31:0] SpinGain = 32'(((64'd285 << FRAC_BITS) + 4) / 8);

  state_t state;
  logic signed [31:0] gx, gy, gz;
  logic [30:0] mass;
  logic signed [31:0] p [3];
  logic signed [31:0] v [3];
  logic signed [31:0] o [3];
  logic signed [31:0] w [3];
  logic signed [31:0] n [3];
  logic signed [31:0] r [3];
  logic signed [31:0] f [3];
  logic signed [31:0] dep;
  logic signed [31:0] dt;
  logic signed [31:0] tmp;
  logic signed [33:0] dot;
  logic signed [31:0] vn;
  logic [1:0] cmd;
  logic [4:0] step;
  logic signed [31:0] ma, mb;
  mul_ctl_t mctl;
  mul_sts_t msts;
  logic signed [31:0] my;
  logic signed [31:0] s_next;
  logic signed [31:0] dclamp;

  rbci_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .ctl(mctl), .a(ma), .b(mb), .sts(msts), .y(my)
  );

  function automatic logic signed [31:0] sadd(input logic signed [31:0] x,
                                              input logic signed [31:0] z);
    return sat34(34'(x) + 34'(z));
  endfunction
  function automatic logic signed [31:0] ssub(input logic signed [31:0] x,
                                              input logic signed [31:0] z);
    return sat34(34'(x) - 34'(z));
  endfunction

  // Multiply operand selection per step of the sequence
  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd == CMD_TICK) begin
      case (step)
        5'd0: begin ma = gx; mb = dt; end
        5'd1: begin ma = gy; mb = dt; end
        5'd2: begin ma = gz; mb = dt; end
        5'd3: begin ma = v[0]; mb = dt; end
        5'd4: begin ma = v[1]; mb = dt; end
        5'd5: begin ma = v[2]; mb = dt; end
        5'd6: begin ma = w[0]; mb = dt; end
        5'd7: begin ma = w[1]; mb = dt; end
        5'd8: begin ma = w[2]; mb = dt; end
        default: ;
      endcase
    end else begin
      case (step)
        5'd0: begin ma = Percent; mb = dclamp; end
        5'd1: begin ma = n[0]; mb = tmp; end
        5'd2: begin ma = n[1]; mb = tmp; end
        5'd3: begin ma = n[2]; mb = tmp; end
        5'd4: begin ma = v[0]; mb = n[0]; end
        5'd5: begin ma = v[1]; mb = n[1]; end
        5'd6: begin ma = v[2]; mb = n[2]; end
        5'd7: begin ma = n[0]; mb = vn; end
        5'd8: begin ma = n[1]; mb = vn; end
        5'd9: begin ma = n[2]; mb = vn; end
        5'd10: begin ma = r[1]; mb = f[2]; end
        5'd11: begin ma = r[2]; mb = f[1]; end
        5'd12: begin ma = r[2]; mb = f[0]; end
        5'd13: begin ma = r[0]; mb = f[2]; end
        5'd14: begin ma = r[0]; mb = f[1]; end
        5'd15: begin ma = r[1]; mb = f[0]; end
        5'd16: begin ma = w[0]; mb = SpinGain; end
        5'd17: begin ma = w[1]; mb = SpinGain; end
        5'd18: begin ma = w[2]; mb = SpinGain; end
        5'd19: begin ma = Bounce; mb = vn; end
        5'd20: begin ma = n[0]; mb = tmp; end
        5'd21: begin ma = n[1]; mb = tmp; end
        5'd22: begin ma = n[2]; mb = tmp; end
        default: ;
      endcase
    end
  end

  assign mctl.start = (state == S_ISS);
  // depth - slop, clamped at zero, feeds the first contact multiply
  assign s_next = ssub(dep, Slop);
  assign dclamp = s_next[31] ? 32'sd0 : s_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gx <= '0;
      gy <= -32'sd642252;
      gz <= '0;
      mass <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GX: gx <= cfg_data;
        REG_GY: gy <= cfg_data;
        REG_GZ: gz <= cfg_data;
        REG_MASS: mass <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Sequencer: issue one multiply per step, fold its result into state; loads write state directly
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      for (int i = 0; i < 3; i++) begin
        p[i] <= '0; v[i] <= '0; o[i] <= '0; w[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd <= in_data.cmd;
            n[0] <= in_data.vec_x;
            n[1] <= in_data.vec_y;
            n[2] <= in_data.vec_z;
            dep <= in_data.depth;
            dt <= {1'b0, in_data.delta};
            step <= '0;
            case (in_data.cmd)
              CMD_LOAD_P: begin
                p[0] <= in_data.vec_x; p[1] <= in_data.vec_y; p[2] <= in_data.vec_z;
                state <= S_OUT;
              end
              CMD_LOAD_O: begin
                o[0] <= in_data.vec_x; o[1] <= in_data.vec_y; o[2] <= in_data.vec_z;
                state <= S_OUT;
              end
              default: state <= S_ISS;
            endcase
          end
        end
        S_ISS: state <= S_WAIT;
        S_WAIT: begin
          if (msts.done) begin
            state <= S_ISS;
            step <= step + 5'd1;
            if (cmd == CMD_TICK) begin
              case (step)
                5'd0, 5'd1, 5'd2: v[step[1:0]] <= sadd(v[step[1:0]], my);
                5'd3: p[0] <= sadd(p[0], my);
                5'd4: p[1] <= sadd(p[1], my);
                5'd5: p[2] <= sadd(p[2], my);
                5'd6: o[0] <= sadd(o[0], my);
                5'd7: o[1] <= sadd(o[1], my);
                default: begin o[2] <= sadd(o[2], my); state <= S_OUT; end
              endcase
            end else begin
              case (step)
                5'd0: tmp <= my;
                5'd1: begin p[0] <= sadd(p[0], my); r[0] <= ssub(sadd(p[0], my), n[0]); end
                5'd2: begin p[1] <= sadd(p[1], my); r[1] <= ssub(sadd(p[1], my), n[1]); end
                5'd3: begin p[2] <= sadd(p[2], my); r[2] <= ssub(sadd(p[2], my), n[2]); end
                5'd4: tmp <= my;
                // dot product kept wide, saturated once at the end
                5'd5: dot <= 34'(tmp) + 34'(my);
                5'd6: vn <= sat34(dot + 34'(my));
                5'd7: f[0] <= ssub(32'sd0, sadd(v[0], my));
                5'd8: f[1] <= ssub(32'sd0, sadd(v[1], my));
                5'd9: f[2] <= ssub(32'sd0, sadd(v[2], my));
                5'd10: tmp <= my;
                5'd11: w[0] <= ssub(tmp, my);
                5'd12: tmp <= my;
                5'd13: w[1] <= ssub(tmp, my);
                5'd14: tmp <= my;
                5'd15: w[2] <= ssub(tmp, my);
                5'd16: w[0] <= my;
                5'd17: w[1] <= my;
                5'd18: w[2] <= my;
                5'd19: tmp <= ssub(32'sd0, my);
                5'd20: v[0] <= sadd(v[0], my);
                5'd21: v[1] <= sadd(v[1], my);
                default: begin v[2] <= sadd(v[2], my); state <= S_OUT; end
              endcase
            end
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data = '{pos_x: p[0], pos_y: p[1], pos_z: p[2],
                      vel_x: v[0], vel_y: v[1], vel_z: v[2],
                      ori_x: o[0], ori_y: o[1], ori_z: o[2],
                      spin_x: w[0], spin_y: w[1], spin_z: w[2]};

`ifndef SYNTHESIS
  // never ready for a request while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready while result pending");
  // multiplier only busy while the sequencer waits on it
  a_mul: assert property (@(posedge clk) disable iff (rst)
    msts.busy |-> (state == S_WAIT)) else $error("multiplier busy out of sequence");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // mass register unaffected by non-config activity
  a_mass: assert property (@(posedge clk) disable iff (rst)
    !$past(cfg_we) |-> $stable(mass)) else $error("mass changed");
`endif
endmodule
